// ===== src/modular_exponentiation_macros.svh =====
// assertion macros shared by the modular exponentiation rtl
// no dependencies; files that assert take this in by include
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH
`ifndef SYNTH
// checked while out of reset
`define MX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("modexp assertion failed");
// checked on every edge, reset included
`define MX_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("modexp assertion failed");
`else
`define MX_ASSERT(lbl, prop)
`define MX_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== src/modexp_pkg.sv =====
// shared types and constants for the modular exponentiation block
// no dependencies
package modexp_pkg;

  localparam int unsigned MOD_W = 30;
  localparam int unsigned EXP_PORT_W = 64;
  localparam int unsigned CNT_W = $clog2(MOD_W + 1);

  typedef logic [MOD_W-1:0] mod_t;

  localparam mod_t PRIME = 30'd1000000007;
  localparam logic [MOD_W+1:0] PRIME_X2 = 32'd2000000014;

  // status of the modular multiplier towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } mm_sts_t;

endpackage

// ===== src/modexp_mulmod.sv =====
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
// depends on modexp_pkg and modular_exponentiation_macros.svh
`include "modular_exponentiation_macros.svh"
module modexp_mulmod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  modexp_pkg::mod_t   a_i,
  input  modexp_pkg::mod_t   b_i,
  output modexp_pkg::mm_sts_t sts_o,
  output modexp_pkg::mod_t   res_o
);
  import modexp_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  mod_t             a_q, a_d;
  mod_t             b_q, b_d;
  mod_t             r_q, r_d;

  logic [MOD_W+1:0] sum;
  logic [MOD_W+1:0] sub1;
  logic [MOD_W+1:0] sub2;
  mod_t             r_next;

  // r = 2r + bit*b, then fold back below the prime (sum < 3p)
  always_comb begin
    sum  = {1'b0, r_q, 1'b0} + (a_q[MOD_W-1] ? {2'b00, b_q} : '0);
    sub1 = sum - {2'b00, PRIME};
    sub2 = sum - PRIME_X2;
    if (sum >= PRIME_X2) begin
      r_next = sub2[MOD_W-1:0];
    end else if (sum >= {2'b00, PRIME}) begin
      r_next = sub1[MOD_W-1:0];
    end else begin
      r_next = sum[MOD_W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(MOD_W);
      a_d    = a_i;
      b_d    = b_i;
      r_d    = '0;
    end else if (busy_q) begin
      r_d   = r_next;
      a_d   = {a_q[MOD_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign res_o      = r_q;

  `MX_ASSERT(mm_res_below_prime, done_q |-> (r_q < PRIME))
  `MX_ASSERT(mm_no_start_busy, start_i |-> (!busy_q))
  `MX_ASSERT(mm_done_ends_busy, done_q |-> (!busy_q))
  `MX_ASSERT(mm_done_not_busy_same, !(busy_q && done_q))

endmodule

// ===== src/modular_exponentiation.sv =====
// modular exponentiation, base to the exponent modulo 1000000007, square and multiply
// one squaring per exponent bit, plus one multiply for each set bit
// one beat at a time; each product is formed by the bit-serial multiplier
// next beat accepted once the result is parked in the output register
// reset (asynchronous, active low) empties the sequencer and the output register
`include "modular_exponentiation_macros.svh"
module modular_exponentiation #(
  parameter int unsigned EXP_WIDTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  modexp_pkg::mod_t                 base_i,
  input  logic [modexp_pkg::EXP_PORT_W-1:0] exponent_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output modexp_pkg::mod_t                 power_mod_o
);
  import modexp_pkg::*;

  localparam int unsigned BIT_CNT_W = $clog2(EXP_WIDTH + 1);

  // sequencer codes
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SQ_GO   = 3'd1;
  localparam logic [2:0] ST_SQ_WAIT = 3'd2;
  localparam logic [2:0] ST_MU_GO   = 3'd3;
  localparam logic [2:0] ST_MU_WAIT = 3'd4;
  localparam logic [2:0] ST_FIN     = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [BIT_CNT_W-1:0] bits_q, bits_d;     // exponent bits still to scan
  logic [EXP_WIDTH-1:0] exp_q, exp_d;       // exponent, msb is the current bit
  mod_t                 base_q, base_d;     // base, already folded below the prime
  mod_t                 acc_q, acc_d;       // running power
  logic                 out_valid_q, out_valid_d;
  mod_t                 out_q, out_d;

  logic                 in_beat;
  logic                 out_free;
  logic                 mm_start;
  mod_t                 mm_b;
  mm_sts_t              mm_sts;
  mod_t                 mm_res;
  logic [2:0]           st_after_bit;

  // new beat only when the sequencer is idle; output parked separately
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;
  // output register may be overwritten when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;

  // squaring uses the running power twice, the multiply step uses the base
  assign mm_start = (state_q == ST_SQ_GO) || (state_q == ST_MU_GO);
  assign mm_b     = (state_q == ST_MU_GO) ? base_q : acc_q;

  // after the last exponent bit the result is ready
  assign st_after_bit = (bits_q == BIT_CNT_W'(1)) ? ST_FIN : ST_SQ_GO;

  always_comb begin
    state_d     = state_q;
    bits_d      = bits_q;
    exp_d       = exp_q;
    base_d      = base_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          // base fits in 30 bits, so one subtract folds it below the prime
          base_d  = (base_i >= PRIME) ? (base_i - PRIME) : base_i;
          exp_d   = exponent_i[EXP_WIDTH-1:0];
          bits_d  = BIT_CNT_W'(EXP_WIDTH);
          acc_d   = mod_t'(1);
          state_d = ST_SQ_GO;
        end
      end
      ST_SQ_GO: begin
        state_d = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (mm_sts.done) begin
          acc_d = mm_res;
          if (exp_q[EXP_WIDTH-1]) begin
            state_d = ST_MU_GO;
          end else begin
            exp_d   = exp_q << 1;
            bits_d  = bits_q - 1'b1;
            state_d = st_after_bit;
          end
        end
      end
      ST_MU_GO: begin
        state_d = ST_MU_WAIT;
      end
      ST_MU_WAIT: begin
        if (mm_sts.done) begin
          acc_d   = mm_res;
          exp_d   = exp_q << 1;
          bits_d  = bits_q - 1'b1;
          state_d = st_after_bit;
        end
      end
      ST_FIN: begin
        // hold here while a previous result still waits downstream
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = acc_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bits_q      <= bits_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q  <= exp_d;
    base_q <= base_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
  end

  modexp_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (acc_q),
    .b_i     (mm_b),
    .sts_o   (mm_sts),
    .res_o   (mm_res)
  );

  assign out_valid_o = out_valid_q;
  assign power_mod_o = out_q;

  `MX_ASSERT(mx_out_below_prime, out_valid_q |-> (out_q < PRIME))
  `MX_ASSERT(mx_beat_starts_seq, in_beat |=> (state_q == ST_SQ_GO))
  `MX_ASSERT(mx_acc_below_prime, (state_q == ST_FIN) |-> (acc_q < PRIME))
  `MX_ASSERT(mx_done_only_waiting, mm_sts.done |-> ((state_q == ST_SQ_WAIT) || (state_q == ST_MU_WAIT)))

endmodule

// ===== bench/modular_exponentiation_tb.sv =====
// self-checking bench for modular_exponentiation: base to a 64-bit exponent mod the prime
// depends on modexp_pkg and the modular_exponentiation rtl; stands alone otherwise
module modular_exponentiation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import modexp_pkg::*;

  localparam int unsigned CLK_PERIOD = 10;
  localparam int unsigned EXP_W = 64;
  // longer than two worst-case exponentiations, so the block backs up into its input
  localparam int unsigned HOLD_OFF_CYCLES = 10000;
  // worst-case latency of one beat plus margin
  localparam int unsigned SETTLE_CYCLES = 4200;
  localparam int unsigned RANDOM_BEATS = 265;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  mod_t                  base_i = '0;
  logic [EXP_PORT_W-1:0] exponent_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  mod_t                  power_mod_o;

  mod_t        pending_powers[$];
  int unsigned beats_sent = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          hold_off_req = 1'b0;

  modular_exponentiation #(
    .EXP_WIDTH(EXP_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .base_i     (base_i),
    .exponent_i (exponent_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .power_mod_o(power_mod_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // square and multiply from the top bit, reducing after every product
  function automatic mod_t modpow(input mod_t b, input logic [EXP_PORT_W-1:0] e);
    logic [63:0] acc;
    logic [63:0] rb;
    logic [63:0] p;
    p   = 64'(PRIME);
    rb  = 64'(b) % p;
    acc = 64'd1;
    for (int i = EXP_W - 1; i >= 0; i--) begin
      acc = (acc * acc) % p;
      if (e[i]) begin
        acc = (acc * rb) % p;
      end
    end
    return mod_t'(acc);
  endfunction

  // mostly short idles, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(20, 80);
  endfunction

  // offer one beat, hold it until taken, then log its expected power
  task automatic send_beat(input mod_t b, input logic [EXP_PORT_W-1:0] e);
    int unsigned gap;
    gap = tx_idle_en ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    base_i     <= b;
    exponent_i <= e;
    do @(posedge clk_i); while (in_stall_o);
    pending_powers.push_back(modpow(b, e));
    beats_sent++;
  endtask

  // sender goes quiet until every expected power has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_powers.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_zero_exponent();
    send_beat('0, '0);
    send_beat(mod_t'(1), '0);
    send_beat(PRIME - mod_t'(1), '0);
    send_beat('1, '0);
    wait_drained();
  endtask

  // bases at or above the prime wrap before use
  task automatic test_unreduced_base();
    send_beat(PRIME, 64'd1);
    send_beat(PRIME + mod_t'(1), 64'd1);
    send_beat('1, 64'd1);
    send_beat('1, 64'd2);
    send_beat(PRIME, '1);
    send_beat('1, '1);
    wait_drained();
  endtask

  task automatic test_exponent_extremes();
    send_beat('0, 64'd1);
    send_beat('0, '1);
    send_beat(PRIME - mod_t'(1), 64'd1);
    send_beat(mod_t'(2), '1);
    send_beat(PRIME - mod_t'(1), '1);
    send_beat(mod_t'(3), 64'h8000_0000_0000_0000);
    // fermat: b^(p-1) is 1, b^(p-2) is the inverse
    send_beat(mod_t'(5), 64'(PRIME) - 64'd1);
    send_beat(mod_t'(5), 64'(PRIME) - 64'd2);
    send_beat(mod_t'(1), {$urandom, $urandom});
    wait_drained();
  endtask

  // output held off long enough that the block fills and stalls the sender
  task automatic test_output_hold_off();
    tx_idle_en   = 1'b0;
    hold_off_req = 1'b1;
    repeat (4) send_beat(mod_t'($urandom), {$urandom, $urandom});
    wait_drained();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_beats();
    mod_t                  b;
    logic [EXP_PORT_W-1:0] e;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      // new idling mode every thirty beats, sometimes after a full drain
      if (n % 30 == 0) begin
        if ($urandom_range(0, 2) == 0) begin
          wait_drained();
        end
        case ($urandom_range(0, 3))
          0: begin tx_idle_en = 1'b1; rx_idle_en = 1'b1; end
          1: begin tx_idle_en = 1'b1; rx_idle_en = 1'b0; end
          2: begin tx_idle_en = 1'b0; rx_idle_en = 1'b1; end
          default: begin tx_idle_en = 1'b0; rx_idle_en = 1'b0; end
        endcase
      end
      case ($urandom_range(0, 9))
        0: b = mod_t'($urandom_range(0, 3));
        1: b = PRIME - mod_t'(3) + mod_t'($urandom_range(0, 6));
        2: b = '1 - mod_t'($urandom_range(0, 3));
        default: b = mod_t'($urandom);
      endcase
      case ($urandom_range(0, 19))
        0, 1, 2: e = 64'($urandom_range(0, 15));
        3, 4: e = 64'd1 << $urandom_range(0, 63);
        5: e = '1 >> $urandom_range(0, 63);
        6: e = 64'(PRIME) - 64'($urandom_range(1, 2));
        default: e = {$urandom, $urandom};
      endcase
      send_beat(b, e);
    end
    wait_drained();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // result-side stall generator; one assignment per iteration
  initial begin : result_stall_gen
    int unsigned hold;
    forever begin
      if (hold_off_req) begin
        hold         = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else if (rx_idle_en) begin
        hold = idle_len();
      end else begin
        hold = 0;
      end
      out_stall_i <= (hold != 0);
      repeat ((hold == 0) ? 1 : hold) @(posedge clk_i);
    end
  end

  // every result beat against the oldest expected power
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_powers.size() == 0) begin
        $error("power_mod: no result expected, got %0d", power_mod_o);
        errors++;
      end else begin
        mod_t want;
        want = pending_powers.pop_front();
        if (power_mod_o !== want) begin
          $error("power_mod: expected %0d, got %0d", want, power_mod_o);
          errors++;
        end
        results_seen++;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_exponent();
    test_unreduced_base();
    test_exponent_extremes();
    test_output_hold_off();
    test_random_beats();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("ran %0d beats and checked %0d results", beats_sent, results_seen);
    $display("zero exponents, unreduced bases, exponent extremes, output hold-off, random idling");
    if (errors == 0 && pending_powers.size() == 0) begin
      $display("PASS modular_exponentiation");
    end else begin
      $display("FAIL modular_exponentiation");
    end
    $finish;
  end

  // timeout well beyond the worst case of the whole run
  initial begin
    #60ms;
    $display("FAIL modular_exponentiation");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/modexp_pkg.sv
src/modexp_mulmod.sv
src/modular_exponentiation.sv
bench/modular_exponentiation_tb.sv
